// ===== sv/skm_pkg.sv =====
// shared types, codes and the semitone table of the sample key map resolver
`default_nettype none

package skm_pkg;

   // request opcodes
   localparam logic [1:0] OP_MARK    = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_RESOLVE = 2'd2;

   // rate arithmetic constants
   localparam logic [8:0] DIST_BIAS    = 9'd132;  // eleven octaves of semitones
   localparam logic [7:0] RECIP_TWELVE = 8'd171;  // 2048/12 rounded up
   localparam int         RECIP_SHIFT  = 11;
   localparam int         OCT_W        = 5;
   localparam logic [4:0] OCT_BIAS     = 5'd11;
   localparam int         SEMI_W       = 4;
   localparam int         TABLE_W      = 21;

   // one request as it arrives
   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] key;
      logic       layer;
   } req_type;

   // one result as it leaves
   typedef struct packed {
      logic [6:0]  ref_key;
      logic [31:0] rate;
      logic        status;
   } rsp_type;

   // outcome of the presence word search
   typedef struct packed {
      logic       own_hit;
      logic       lower_found;
      logic [6:0] lower;
      logic       upper_found;
      logic [6:0] upper;
   } search_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_PICK,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // 2^(s/12) in Q1.20, rounded to nearest
   function automatic logic [TABLE_W-1:0] semitone_q20(input logic [SEMI_W-1:0] s);
      logic [TABLE_W-1:0] t;
      case (s)
         4'd0:    t = 21'd1048576;
         4'd1:    t = 21'd1110928;
         4'd2:    t = 21'd1176987;
         4'd3:    t = 21'd1246974;
         4'd4:    t = 21'd1321123;
         4'd5:    t = 21'd1399681;
         4'd6:    t = 21'd1482910;
         4'd7:    t = 21'd1571089;
         4'd8:    t = 21'd1664511;
         4'd9:    t = 21'd1763488;
         4'd10:   t = 21'd1868350;
         4'd11:   t = 21'd1979448;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/skm_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module skm_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/skm_search.sv =====
// nearest loaded key search over one layer's presence word
`default_nettype none

module skm_search #(
   parameter int KEY_COUNT = 128
) (
   input  wire logic [KEY_COUNT-1:0] word,
   input  wire logic [6:0]           key,
   output skm_pkg::search_type       result
);

   localparam int KEY_IDX_W = $clog2(KEY_COUNT);

   logic key_ok;

   assign key_ok = {1'b0, key} < 8'(KEY_COUNT);

   // own bit, then priority encoders below and above the key
   always_comb begin
      result = '0;
      result.own_hit = key_ok && word[key[KEY_IDX_W-1:0]];
      // highest set bit below the key
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (word[k] && (7'(k) < key)) begin
            result.lower_found = 1'b1;
            result.lower       = 7'(k);
         end
      end
      // lowest set bit above the key
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (word[k] && (7'(k) > key)) begin
            result.upper_found = 1'b1;
            result.upper       = 7'(k);
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/skm_rate.sv =====
// playback rate unit: octave split of the distance, then table lookup and shift
`default_nettype none

module skm_rate (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic signed [7:0] delta,
   output logic [31:0]            rate
);

   logic [skm_pkg::OCT_W-1:0]   oct_ff, oct_in;
   logic [skm_pkg::SEMI_W-1:0]  semi_ff, semi_in;
   logic [8:0]                  biased;
   logic [15:0]                 prod;
   logic [8:0]                  rem;
   logic [skm_pkg::TABLE_W-1:0] step;
   logic [3:0]                  shl;
   logic [3:0]                  shr;

   // split biased distance into octave and semitone by reciprocal multiply
   always_comb begin
      biased  = {delta[7], delta} + skm_pkg::DIST_BIAS;
      prod    = 16'(biased * skm_pkg::RECIP_TWELVE);
      oct_in  = prod[skm_pkg::RECIP_SHIFT +: skm_pkg::OCT_W];
      rem     = biased - {oct_in, 3'b000} - {2'b00, oct_in, 2'b00};
      semi_in = rem[skm_pkg::SEMI_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         oct_ff  <= oct_in;
         semi_ff <= semi_in;
      end
   end

   // scale the semitone step by whole octaves, rounding half up going down
   always_comb begin
      step = skm_pkg::semitone_q20(semi_ff);
      shl  = 4'(oct_ff - skm_pkg::OCT_BIAS);
      shr  = 4'(skm_pkg::OCT_BIAS - oct_ff);
      if (oct_ff >= skm_pkg::OCT_BIAS) begin
         rate = 32'(step) << shl;
      end else begin
         rate = (32'(step) + (32'd1 << (shr - 4'd1))) >> shr;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sample_key_map_resolver.sv =====
// top level of the sample key map resolver
//
// Keeps one presence word per layer in a ram (row = layer, bit = key).
// Requests enter on req_cmd and are taken at a clock edge where start is
// high and busy is low. Mark and clear requests read the layer's word,
// set or clear one bit and write it back; they give no result and keep
// busy high for one cycle.
// A resolve request reads the word, searches for the own key or the
// nearest loaded key below and above (upper wins a tie), then splits the
// distance into octave and semitone and scales a semitone table entry.
// Its result appears on rsp_data with rsp_strobe high for exactly one cycle,
// after the ram read, search, pick, rate unit and result registers in turn;
// busy stays high until the result is registered, so a new resolve is not
// taken while one is in progress.
// The result register holds the result apart from the request side, so a
// new request may be taken in the cycle the strobe is shown. The receiver
// cannot stall and must take each result in its strobe cycle.
// Reset clears the sequencer and the per-layer valid bits, so every layer
// reads as empty at once; no clearing pass is needed.
`default_nettype none

module sample_key_map_resolver #(
   parameter int KEY_COUNT   = 128,
   parameter int LAYER_COUNT = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire skm_pkg::req_type req_cmd,
   output logic                  rsp_strobe,
   output skm_pkg::rsp_type      rsp_data
);

   localparam int ADDR_W    = LAYER_COUNT > 1 ? $clog2(LAYER_COUNT) : 1;
   localparam int KEY_IDX_W = $clog2(KEY_COUNT);

   skm_pkg::state_type  state_ff, state_in;
   skm_pkg::req_type    cmd_ff, cmd_in;
   logic [LAYER_COUNT-1:0] row_valid_ff, row_valid_in;
   skm_pkg::search_type srch_ff, srch_in;
   logic [6:0]          target_ff, target_in;
   logic signed [7:0]   dist_ff, dist_in;
   logic                none_ff, none_in;
   skm_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                req_layer_ok;
   logic                layer_ok;
   logic                key_ok;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   row_addr;
   logic                rd_en;
   logic                wr_en;
   logic [KEY_COUNT-1:0] rd_data;
   logic [KEY_COUNT-1:0] word;
   logic [KEY_COUNT-1:0] wr_data;
   logic                scale_load;
   logic [31:0]         rate;
   logic [6:0]          gap_lower;
   logic [6:0]          gap_upper;

   // layer and key range checks
   assign req_layer_ok = (LAYER_COUNT > 1) || (req_cmd.layer == 1'b0);
   assign layer_ok     = (LAYER_COUNT > 1) || (cmd_ff.layer == 1'b0);
   assign key_ok       = {1'b0, cmd_ff.key} < 8'(KEY_COUNT);
   assign rd_addr      = req_layer_ok ? ADDR_W'(req_cmd.layer) : '0;
   assign row_addr     = layer_ok ? ADDR_W'(cmd_ff.layer) : '0;

   // presence word store
   skm_ram #(
      .WIDTH (KEY_COUNT),
      .DEPTH (LAYER_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a row never written since reset reads as empty
   assign word = (layer_ok && row_valid_ff[row_addr]) ? rd_data : '0;

   // modified word for mark and clear
   always_comb begin
      wr_data = word;
      wr_data[cmd_ff.key[KEY_IDX_W-1:0]] = (cmd_ff.opcode == skm_pkg::OP_MARK);
   end

   // nearest key search
   skm_search #(
      .KEY_COUNT (KEY_COUNT)
   ) u_search (
      .word   (word),
      .key    (cmd_ff.key),
      .result (srch_in)
   );

   // octave and semitone scaling
   skm_rate u_rate (
      .clock (clock),
      .load  (scale_load),
      .delta (dist_ff),
      .rate  (rate)
   );

   assign gap_lower = cmd_ff.key - srch_ff.lower;
   assign gap_upper = srch_ff.upper - cmd_ff.key;

   // sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_valid_in  = row_valid_ff;
      target_in     = target_ff;
      dist_in       = dist_ff;
      none_in       = none_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      scale_load    = 1'b0;
      case (state_ff)
         skm_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               rd_en    = 1'b1;
               state_in = skm_pkg::ST_LOOKUP;
            end
         end
         skm_pkg::ST_LOOKUP: begin
            state_in = skm_pkg::ST_IDLE;
            if (cmd_ff.opcode inside {skm_pkg::OP_MARK, skm_pkg::OP_CLEAR}) begin
               if (layer_ok && key_ok) begin
                  wr_en                  = 1'b1;
                  row_valid_in[row_addr] = 1'b1;
               end
            end else if (cmd_ff.opcode == skm_pkg::OP_RESOLVE) begin
               state_in = skm_pkg::ST_PICK;
            end
         end
         skm_pkg::ST_PICK: begin
            none_in = 1'b0;
            if (srch_ff.own_hit) begin
               target_in = cmd_ff.key;
            end else if (!srch_ff.lower_found && !srch_ff.upper_found) begin
               target_in = '0;
               none_in   = 1'b1;
            end else if (!srch_ff.lower_found) begin
               target_in = srch_ff.upper;
            end else if (!srch_ff.upper_found) begin
               target_in = srch_ff.lower;
            end else if (gap_lower < gap_upper) begin
               target_in = srch_ff.lower;
            end else begin
               target_in = srch_ff.upper;
            end
            dist_in  = $signed({1'b0, cmd_ff.key} - {1'b0, target_in});
            state_in = skm_pkg::ST_SCALE;
         end
         skm_pkg::ST_SCALE: begin
            scale_load = 1'b1;
            state_in   = skm_pkg::ST_EMIT;
         end
         skm_pkg::ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            if (none_ff) begin
               rsp_in.ref_key = '0;
               rsp_in.rate    = '0;
               rsp_in.status  = 1'b1;
            end else begin
               rsp_in.ref_key = target_ff;
               rsp_in.rate    = rate;
               rsp_in.status  = 1'b0;
            end
            state_in = skm_pkg::ST_IDLE;
         end
         default: begin
            state_in = skm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= skm_pkg::ST_IDLE;
         row_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      srch_ff   <= srch_in;
      target_ff <= target_in;
      dist_ff   <= dist_in;
      none_ff   <= none_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != skm_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/skm_checker.sv =====
// port-level checks of the sample key map resolver and their binding
`default_nettype none

module skm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire skm_pkg::req_type req_cmd,
   input wire logic             rsp_strobe,
   input wire skm_pkg::rsp_type rsp_data
);

   // a resolve request gives its result a fixed time later
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd.opcode == skm_pkg::OP_RESOLVE) |-> ##5 rsp_strobe)
      else $error("resolve request without result at fixed latency");

   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // results come from work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // an empty layer answers with zero key and zero rate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status) |-> (rsp_data.ref_key == '0 && rsp_data.rate == '0))
      else $error("no-sample result carries key or rate");

endmodule

bind sample_key_map_resolver skm_checker u_skm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_cmd    (req_cmd),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
